/* src/pshtu_pkg.sv */
// shared types and constants for the point set hyperplane test unit
package pshtu_pkg;

   localparam int MAX_COORDS_DEF = 6;
   localparam int COORD_BITS_DEF = 8;
   localparam int MAX_POINTS_DEF = 256;

   localparam logic [1:0] CSR_PRIME     = 2'd0;
   localparam logic [1:0] CSR_DIMS      = 2'd1;
   localparam logic [1:0] CSR_TEST_KIND = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic store_wr;    // write accepted point at fill count
      logic count_clr;   // clear fill count and overflow
      logic form_init;   // lead 0, digit 0 one, other digits zero
      logic form_next;   // step to next form
      logic scan_start;  // point index 0, hit count 0
      logic scan_issue;  // issue read of next point
      logic scan_acc;    // accumulate point from memory
      logic mac_step;    // one coordinate multiply accumulate step
      logic mac_start;   // begin dot product of read point
   } pshtu_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;        // store holds max points
      logic count_lt_d;  // fewer than d points
      logic count_zero;
      logic overflow;
      logic scan_last;   // last point issued
      logic mac_done;    // dot product finished
      logic form_last;   // current form was the last one
      logic fail_now;    // hit count decides failure
   } pshtu_sts_type;

endpackage

/* src/point_set_hyperplane_test_unit.sv */
// top level of the point set hyperplane test unit
// load: one point beat per cycle into the point store, also while a result waits
// sweep: per hyperplane each stored point is read and latched, then each of its d coordinates is multiplied
// and reduced mod p four bits at a time; the sweep starts once the last result left
// synchronous active high reset clears fill count, overflow, config and controller
module point_set_hyperplane_test_unit #(
   parameter int MAX_COORDS = pshtu_pkg::MAX_COORDS_DEF,
   parameter int COORD_BITS = pshtu_pkg::COORD_BITS_DEF,
   parameter int MAX_POINTS = pshtu_pkg::MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [((MAX_COORDS*COORD_BITS+7)/8)*8-1:0] req_tdata, // coord_0..coord_n
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata, // verdict, status, set_size, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [7:0] prime_ff;
   logic [2:0] dims_ff;
   logic       kind_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= 8'd2;
         dims_ff  <= 3'd3;
         kind_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pshtu_pkg::CSR_PRIME:     prime_ff <= csr_data;
            pshtu_pkg::CSR_DIMS:      dims_ff  <= csr_data[2:0];
            pshtu_pkg::CSR_TEST_KIND: kind_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   pshtu_pkg::pshtu_cmd_type cmd;
   pshtu_pkg::pshtu_sts_type sts;
   logic [CW-1:0] count;
   logic [CW-1:0] size_ff;
   logic          ver, stat;

   pshtu_datapath #(.MAX_COORDS(MAX_COORDS), .COORD_BITS(COORD_BITS),
                    .MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .point_in(req_tdata[MAX_COORDS*COORD_BITS-1:0]),
      .prime(prime_ff), .dims(dims_ff), .test_kind(kind_ff), .count_out(count)
   );

   pshtu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .test_kind(kind_ff),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_last(req_tlast),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_verdict(ver), .out_status(stat), .cmd(cmd), .sts(sts)
   );

   always_ff @(posedge clock) begin
      if (cmd.count_clr) size_ff <= count;
   end

   assign rsp_tdata = {5'd0, 9'(size_ff), stat, ver};
endmodule

/* src/pshtu_ram.sv */
// generic single port write, single port read ram with registered read
module pshtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

/* src/pshtu_datapath.sv */
// point store, form counter, dot product unit and hit counter
module pshtu_datapath #(
   parameter int MAX_COORDS = pshtu_pkg::MAX_COORDS_DEF,
   parameter int COORD_BITS = pshtu_pkg::COORD_BITS_DEF,
   parameter int MAX_POINTS = pshtu_pkg::MAX_POINTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pshtu_pkg::pshtu_cmd_type             cmd,
   output pshtu_pkg::pshtu_sts_type             sts,
   input  logic [MAX_COORDS*COORD_BITS-1:0]     point_in,
   input  logic [7:0]                           prime,
   input  logic [2:0]                           dims,
   input  logic                                 test_kind,
   output logic [$clog2(MAX_POINTS+1)-1:0]      count_out
);
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int JW  = $clog2(MAX_COORDS + 1);
   localparam int DI  = $clog2(MAX_COORDS);
   localparam int PW  = 8;
   // acc + dig*coord stays below 2^(PW+COORD_BITS)
   localparam int VW  = PW + COORD_BITS;
   // remainder is taken four bits a cycle
   localparam int NCH = (VW + 3) / 4;
   localparam int VWP = NCH * 4;
   localparam int CHW = $clog2(NCH + 1);

   // effective modulus and dims
   logic [PW-1:0] p_eff;
   logic [JW-1:0] d_eff;
   always_comb begin
      p_eff = (prime < 8'd2) ? 8'd2 : prime;
      if (dims < 3'd2) d_eff = JW'(2);
      else if (32'(dims) > MAX_COORDS) d_eff = JW'(MAX_COORDS);
      else d_eff = JW'(dims);
   end

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [MAX_COORDS*COORD_BITS-1:0] rd_data;

   // form digits, lead position
   logic [PW-1:0] dig_ff [MAX_COORDS];
   logic [PW-1:0] dig_in [MAX_COORDS];
   logic [JW-1:0] lead_ff, lead_in;
   logic [CW-1:0] idx_ff, idx_in, hit_ff, hit_in;
   // dot product unit: latched point, coordinate index, accumulator
   logic [COORD_BITS-1:0] pt_ff [MAX_COORDS];
   logic [COORD_BITS-1:0] pt_in [MAX_COORDS];
   logic [JW-1:0] j_ff, j_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic          busy_ff, busy_in;
   // serial remainder: dividend shift register, partial remainder, chunk count
   logic [VWP-1:0] val_ff, val_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [CHW-1:0] ch_ff, ch_in;
   logic           ld_ff, ld_in;

   logic          carry;
   logic [DI-1:0] jx;
   logic [VW-1:0] prod;
   logic [PW:0]   rem_wk;

   assign jx = j_ff[DI-1:0];

   pshtu_ram #(.WIDTH(MAX_COORDS*COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_wr && (count_ff < CW'(MAX_POINTS))),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (point_in),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      for (int i = 0; i < MAX_COORDS; i++) dig_in[i] = dig_ff[i];
      lead_in  = lead_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      for (int i = 0; i < MAX_COORDS; i++) pt_in[i] = pt_ff[i];
      j_in     = j_ff;
      acc_in   = acc_ff;
      busy_in  = busy_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      ch_in    = ch_ff;
      ld_in    = ld_ff;
      carry    = 1'b1;
      prod     = '0;
      rem_wk   = '0;

      if (cmd.count_clr) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.store_wr) begin
         if (count_ff < CW'(MAX_POINTS)) count_in = count_ff + CW'(1);
         else ovf_in = 1'b1;
      end

      if (cmd.form_init) begin
         for (int i = 0; i < MAX_COORDS; i++) dig_in[i] = '0;
         dig_in[0] = PW'(1);
         lead_in   = '0;
      end else if (cmd.form_next) begin
         // increment digits after lead, low-order digit is the last coordinate
         for (int i = MAX_COORDS - 1; i >= 0; i--) begin
            if (carry && (i < int'(d_eff)) && (i > int'(lead_ff))) begin
               if (dig_ff[i] + PW'(1) < p_eff) begin
                  dig_in[i] = dig_ff[i] + PW'(1);
                  carry     = 1'b0;
               end else begin
                  dig_in[i] = '0;
               end
            end
         end
         if (carry) begin
            for (int i = 0; i < MAX_COORDS; i++) dig_in[i] = '0;
            lead_in = lead_ff + JW'(1);
            for (int i = 0; i < MAX_COORDS; i++)
               if (JW'(i) == lead_ff + JW'(1)) dig_in[i] = PW'(1);
         end
      end

      if (cmd.scan_start) begin
         idx_in = '0;
         hit_in = '0;
      end else if (cmd.scan_issue) begin
         idx_in = idx_ff + CW'(1);
      end

      if (cmd.mac_start) begin
         for (int i = 0; i < MAX_COORDS; i++)
            pt_in[i] = rd_data[i*COORD_BITS +: COORD_BITS];
         j_in    = '0;
         acc_in  = '0;
         ld_in   = 1'b1;
         busy_in = 1'b1;
      end else if (cmd.mac_step && busy_ff) begin
         if (ld_ff) begin
            // form acc + dig*coord, reduced mod p over the next cycles
            prod   = VW'(dig_ff[jx]) * VW'(pt_ff[jx]);
            val_in = VWP'(prod + VW'(acc_ff));
            rem_in = '0;
            ch_in  = '0;
            ld_in  = 1'b0;
         end else begin
            // long division, msb first, four bits a cycle
            rem_wk = {1'b0, rem_ff};
            for (int b = 0; b < 4; b++) begin
               rem_wk = {rem_wk[PW-1:0], val_ff[VWP-1-b]};
               if (rem_wk >= {1'b0, p_eff}) rem_wk = rem_wk - {1'b0, p_eff};
            end
            rem_in = rem_wk[PW-1:0];
            val_in = {val_ff[VWP-5:0], 4'b0};
            ch_in  = ch_ff + CHW'(1);
            if (ch_ff == CHW'(NCH - 1)) begin
               acc_in = rem_wk[PW-1:0];
               ld_in  = 1'b1;
               j_in   = j_ff + JW'(1);
               if (j_ff + JW'(1) == d_eff) begin
                  busy_in = 1'b0;
                  if (rem_wk[PW-1:0] == '0) hit_in = hit_ff + CW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         lead_ff  <= '0;
         idx_ff   <= '0;
         hit_ff   <= '0;
         busy_ff  <= 1'b0;
         j_ff     <= '0;
         acc_ff   <= '0;
         val_ff   <= '0;
         rem_ff   <= '0;
         ch_ff    <= '0;
         ld_ff    <= 1'b0;
         for (int i = 0; i < MAX_COORDS; i++) dig_ff[i] <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         lead_ff  <= lead_in;
         idx_ff   <= idx_in;
         hit_ff   <= hit_in;
         busy_ff  <= busy_in;
         j_ff     <= j_in;
         acc_ff   <= acc_in;
         val_ff   <= val_in;
         rem_ff   <= rem_in;
         ch_ff    <= ch_in;
         ld_ff    <= ld_in;
         for (int i = 0; i < MAX_COORDS; i++) dig_ff[i] <= dig_in[i];
      end
      for (int i = 0; i < MAX_COORDS; i++) pt_ff[i] <= pt_in[i];
   end

   logic all_max;
   always_comb begin
      all_max = 1'b1;
      for (int i = 0; i < MAX_COORDS; i++)
         if ((i < int'(d_eff)) && (i > int'(lead_ff)) && (dig_ff[i] != p_eff - PW'(1)))
            all_max = 1'b0;
   end

   assign count_out      = count_ff;
   assign sts.full       = (count_ff == CW'(MAX_POINTS));
   assign sts.count_lt_d = (count_ff < CW'(d_eff));
   assign sts.count_zero = (count_ff == '0);
   assign sts.overflow   = ovf_ff;
   assign sts.scan_last  = (idx_ff == count_ff);
   assign sts.mac_done   = !busy_ff;
   assign sts.form_last  = all_max && (lead_ff + JW'(1) >= d_eff);
   assign sts.fail_now   = test_kind ? (hit_ff == '0) : (hit_ff >= CW'(d_eff));
endmodule

/* src/pshtu_ctrl.sv */
// controller state machine: load, sweep, result
module pshtu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     test_kind,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     in_last,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic                     out_verdict,
   output logic                     out_status,
   output pshtu_pkg::pshtu_cmd_type cmd,
   input  pshtu_pkg::pshtu_sts_type sts
);
   typedef enum logic [2:0] {
      ST_LOAD, ST_DECIDE, ST_ISSUE, ST_WAIT, ST_MAC, ST_CHECK, ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in, ver_ff, ver_in, stat_ff, stat_in;

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff;
      ver_in   = ver_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      in_ready = 1'b0;
      if (vld_ff && out_ready) vld_in = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.store_wr = 1'b1;
               if (in_last) state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // previous result still waiting in the output register
            if (!vld_ff) begin
               cmd.form_init  = 1'b1;
               cmd.scan_start = 1'b1;
               priority if (sts.overflow) begin
                  ver_in = 1'b0; stat_in = 1'b1; state_in = ST_RESULT;
               end else if (!test_kind && sts.count_lt_d) begin
                  ver_in = 1'b1; stat_in = 1'b0; state_in = ST_RESULT;
               end else if (test_kind && sts.count_zero) begin
                  ver_in = 1'b0; stat_in = 1'b0; state_in = ST_RESULT;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (sts.scan_last) begin
               state_in = ST_CHECK;
            end else begin
               cmd.scan_issue = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            cmd.mac_start = 1'b1;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_step = 1'b1;
            if (sts.mac_done) state_in = ST_ISSUE;
         end
         ST_CHECK: begin
            stat_in = 1'b0;
            priority if (sts.fail_now) begin
               ver_in = 1'b0; state_in = ST_RESULT;
            end else if (sts.form_last) begin
               ver_in = 1'b1; state_in = ST_RESULT;
            end else begin
               cmd.form_next  = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_RESULT: begin
            if (!vld_ff) begin
               vld_in = 1'b1;
               cmd.count_clr = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         vld_ff   <= 1'b0;
         ver_ff   <= 1'b0;
         stat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         ver_ff   <= ver_in;
         stat_ff  <= stat_in;
      end
   end

   assign out_valid   = vld_ff;
   assign out_verdict = ver_ff;
   assign out_status  = stat_ff;
endmodule

/* dv/tb_point_set_hyperplane_test_unit.sv */
// testbench for the point set hyperplane test unit: queued point sets, self-checked verdicts
`timescale 1ns / 1ps

module tb_point_set_hyperplane_test_unit;

   localparam int NCOORD = 6;
   localparam int NPTS = 256;
   localparam int IDLE_LIMIT = 400000;

   typedef struct {
      logic [47:0] coords;
      bit          last;
   } point_beat_type;

   typedef struct {
      bit       verdict;
      bit       status;
      bit [8:0] size;
   } verdict_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   point_beat_type point_q[$];
   verdict_type    verdict_q[$];
   int          fails = 0;
   int          idle_cycles = 0;
   int          rsp_seen = 0;
   bit          long_done = 0;

   // shadow of the block's configuration and point store
   logic [7:0]  m_prime = 8'd2;
   logic [2:0]  m_dims = 3'd3;
   logic        m_kind = 1'b0;
   logic [7:0]  m_store [NPTS][NCOORD];
   int          m_count = 0;
   bit          m_ovf = 0;

   point_set_hyperplane_test_unit dut (.*);

   always #5 clock = ~clock;

   function automatic bit set_passes(int d, int p, bit blk);
      int form [NCOORD];
      int lead, j, k, hits, acc;
      bit carried;
      if (!blk && m_count < d) return 1;
      if (blk && m_count == 0) return 0;
      for (lead = 0; lead < d; lead++) begin
         foreach (form[i]) form[i] = 0;
         form[lead] = 1;
         while (1) begin
            hits = 0;
            for (k = 0; k < m_count; k++) begin
               acc = 0;
               for (j = 0; j < d; j++)
                  acc = (acc + form[j] * (int'(m_store[k][j]) % p)) % p;
               if (acc == 0) hits++;
            end
            if (blk ? (hits == 0) : (hits >= d)) return 0;
            carried = 1;
            j = d;
            while (j > lead + 1) begin
               j--;
               form[j]++;
               if (form[j] < p) begin
                  carried = 0;
                  break;
               end
               form[j] = 0;
            end
            if (carried) break;
         end
      end
      return 1;
   endfunction

   task automatic predict_point(point_beat_type b);
      verdict_type v;
      int d, p;
      if (m_count < NPTS) begin
         for (int i = 0; i < NCOORD; i++) m_store[m_count][i] = b.coords[8*i +: 8];
         m_count++;
      end else begin
         m_ovf = 1;
      end
      if (b.last) begin
         p = (m_prime < 2) ? 2 : m_prime;
         d = (m_dims < 2) ? 2 : ((m_dims > NCOORD) ? NCOORD : m_dims);
         v.verdict = m_ovf ? 1'b0 : set_passes(d, p, m_kind);
         v.status = m_ovf;
         v.size = m_count[8:0];
         verdict_q.insert(verdict_q.size(), v);
         m_count = 0;
         m_ovf = 0;
      end
   endtask

   // driver
   int drv_gap = 0;
   int drv_cyc = 0;
   always @(posedge clock) begin
      logic nv;
      int r;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         drv_cyc++;
         nv = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_point(point_q.pop_front());
            r = $urandom_range(0, 99);
            // every other window of the driver cycle count runs without gaps
            if ((drv_cyc / 500) % 2 == 0) drv_gap = 0;
            else drv_gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 60);
            nv = 0;
         end
         if (!nv) begin
            if (drv_gap > 0) drv_gap--;
            else if (point_q.size() > 0) begin
               nv = 1;
               req_tdata <= point_q[0].coords;
               req_tlast <= point_q[0].last;
            end
         end
         req_tvalid <= nv;
      end
   end

   // monitor
   int mon_gap = 0;
   int mon_cyc = 0;
   always @(posedge clock) begin
      verdict_type v;
      int r;
      if (!reset) begin
         mon_cyc++;
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected verdict beat %h", $realtime, rsp_tdata);
               fails++;
            end else begin
               v = verdict_q.pop_front();
               if (rsp_tdata[0] !== v.verdict) begin
                  $display("%0t: verdict exp %0d got %0d", $realtime, v.verdict, rsp_tdata[0]);
                  fails++;
               end
               if (rsp_tdata[1] !== v.status) begin
                  $display("%0t: status exp %0d got %0d", $realtime, v.status, rsp_tdata[1]);
                  fails++;
               end
               if (rsp_tdata[10:2] !== v.size) begin
                  $display("%0t: set_size exp %0d got %0d", $realtime, v.size,
                           rsp_tdata[10:2]);
                  fails++;
               end
            end
            // long hold while points are still queued so the block backs up into its input
            if (!long_done && rsp_seen >= 12 && point_q.size() > 20) begin
               mon_gap = 3000;
               long_done = 1;
            end else begin
               r = $urandom_range(0, 99);
               if ((mon_cyc / 700) % 2 == 0) mon_gap = 0;
               else mon_gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4)
                                                      : $urandom_range(20, 80);
            end
         end
         if (mon_gap > 0) begin
            mon_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         pshtu_pkg::CSR_PRIME:     m_prime = val;
         pshtu_pkg::CSR_DIMS:      m_dims = val[2:0];
         pshtu_pkg::CSR_TEST_KIND: m_kind = val[0];
         default: ;
      endcase
   endtask

   // sender waits here until the block has drained
   task automatic drain();
      while (point_q.size() > 0 || verdict_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic configure(int p, int d, int k);
      drain();
      write_reg(pshtu_pkg::CSR_PRIME, p[7:0]);
      write_reg(pshtu_pkg::CSR_DIMS, d[7:0]);
      write_reg(pshtu_pkg::CSR_TEST_KIND, k[7:0]);
   endtask

   function automatic logic [47:0] rand_point(int p);
      logic [47:0] c;
      int r;
      int pe;
      pe = (p < 2) ? 2 : p;
      r = $urandom_range(0, 99);
      c = '0;
      if (r < 5) return c;
      for (int i = 0; i < NCOORD; i++)
         c[8*i +: 8] = (r < 15) ? 8'($urandom) : 8'($urandom_range(0, pe - 1));
      return c;
   endfunction

   task automatic add_set(int n, int p);
      point_beat_type b;
      for (int i = 0; i < n; i++) begin
         b.coords = rand_point(p);
         b.last = (i == n - 1);
         point_q.insert(point_q.size(), b);
      end
   endtask

   task automatic add_fixed(logic [47:0] c, bit last);
      point_beat_type b;
      b.coords = c;
      b.last = last;
      point_q.insert(point_q.size(), b);
   endtask

   task automatic random_phase(int p, int d, int k, int items, int max_set);
      int sent, n;
      configure(p, d, k);
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(0, 9) == 0) ? max_set : $urandom_range(1, max_set);
         add_set(n, p);
         sent += n;
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed: reset config, clamped configs, zero and all-ones points, few points, repeats
      add_fixed(48'h0, 1);
      add_fixed(48'hFFFFFF_FFFFFF, 0);
      add_fixed(48'h000000_000001, 0);
      add_fixed(48'h000000_000100, 0);
      add_fixed(48'h000000_010000, 1);
      add_fixed(48'h000000_010101, 0);
      add_fixed(48'h000000_010101, 0);
      add_fixed(48'h000000_000000, 1);
      drain();
      configure(255, 2, 1);
      add_fixed(48'h0000_0000_FEFF, 0);
      add_fixed(48'h0000_0000_00FE, 1);
      configure(0, 0, 0);
      add_fixed(48'h0000_0000_0001, 0);
      add_fixed(48'h0000_0000_0100, 0);
      add_fixed(48'h0000_0000_0101, 1);
      configure(1, 7, 1);
      add_fixed(48'h0101_0101_0101, 0);
      add_fixed(48'hFFFF_FFFF_FFFF, 1);
      configure(4, 3, 0);
      add_fixed(48'h0000_0002_0202, 0);
      add_fixed(48'h0000_0001_0203, 0);
      add_fixed(48'h0000_0003_0000, 1);
      drain();
      // store full and overflow
      configure(2, 2, 0);
      add_set(256, 2);
      add_set(257, 2);
      add_set(260, 2);
      drain();
      random_phase(3, 3, 0, 90, 10);
      random_phase(3, 3, 1, 90, 10);
      random_phase(2, 4, 0, 70, 10);
      random_phase(2, 4, 1, 70, 10);
      random_phase(5, 3, 1, 70, 10);
      random_phase(5, 3, 0, 60, 8);
      random_phase(2, 6, 1, 60, 10);
      random_phase(2, 6, 0, 50, 10);
      random_phase(7, 2, 1, 60, 8);
      random_phase(255, 2, 0, 40, 4);
      random_phase(255, 2, 1, 30, 3);
      random_phase(1, 1, 1, 40, 6);
      random_phase(6, 2, 0, 40, 6);
      random_phase(3, 7, 1, 30, 5);
      while (verdict_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fails == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
